// ===== sv/block_average_color_run_encoder_defines.svh =====
`ifndef BLOCK_AVERAGE_COLOR_RUN_ENCODER_DEFINES_SVH
`define BLOCK_AVERAGE_COLOR_RUN_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BACRE_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bacre: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BACRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bacre: assertion failed");

`endif

// ===== sv/bacre_pkg.sv =====
package bacre_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_BLOCK = 64;

    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int SUM_W      = 20;
    localparam int AREA_W     = 14;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int BLK_W      = 7;
    localparam int ROW_W      = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [IMG_H_W-1:0] MAX_HEIGHT = 13'd4096;

    typedef enum logic [1:0] {
        TOK_SET     = 2'd0,
        TOK_RESET   = 2'd1,
        TOK_SPACE   = 2'd2,
        TOK_NEWLINE = 2'd3
    } token_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BLOCK_WIDTH  = 2'd2,
        CFG_BLOCK_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_COLOR,
        S_SPACE,
        S_RESET,
        S_NEWLINE
    } state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        token_t            token;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_of_run;
    } token_item_t;

    typedef struct packed {
        logic   accept;
        logic   acc;
        logic   div_step;
        logic   push;
        token_t tok_code;
        logic   last_run;
        logic   commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_tile;
        logic last;
        logic rowend;
        logic need_color;
        logic need_reset;
        logic avg_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/bacre_pixel_if.sv =====
interface bacre_pixel_if import bacre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/bacre_token_if.sv =====
interface bacre_token_if import bacre_pkg::*; ();
    logic              valid;
    logic              ready;
    token_t            token;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              last_of_run;

    modport source (output valid, output token, output out_red, output out_green,
                    output out_blue, output last_of_run, input ready);
    modport sink   (input valid, input token, input out_red, input out_green,
                    input out_blue, input last_of_run, output ready);
endinterface

// ===== sv/bacre_ram.sv =====
module bacre_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bacre_datapath.sv =====
module bacre_datapath import bacre_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  pixel_t                pix,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            sts,
    output token_item_t           tok,
    output logic                  tok_valid,
    input  logic                  tok_ready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam logic [IMG_W_W:0] MaxWidth = (IMG_W_W + 1)'(MAX_WIDTH);
    localparam logic [8:0]       MaxBlock = 9'(MAX_BLOCK);

    logic [IMG_W_W-1:0] img_w_reg;
    logic [IMG_H_W-1:0] img_h_reg;
    logic [BLK_W-1:0]   blk_w_reg;
    logic [BLK_W-1:0]   blk_h_reg;

    logic [IMG_W_W-1:0] w_c;
    logic [IMG_H_W-1:0] h_c;
    logic [BLK_W-1:0]   bw_c;
    logic [BLK_W-1:0]   bh_c;
    logic [AREA_W-1:0]  area_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] tstart_reg;
    logic [COL_W-1:0] tile_reg;
    logic [BLK_W-1:0] cx_reg;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] rstart_reg;
    logic [BLK_W-1:0] ry_reg;

    logic col_end, row_last, cx_end, ry_end, in_col, in_row, in_tile;

    pixel_t           px_reg;
    logic             first_reg, last_reg, rowend_reg, wrap_reg;
    logic [COL_W-1:0] tidx_reg;

    logic [3*SUM_W-1:0] rd_data;
    logic [3*SUM_W-1:0] wr_data;
    logic [SUM_W-1:0]   sum [3];
    logic [CHAN_W-1:0]  px_c [3];

    logic [SUM_W-1:0]  quo_reg [3];
    logic [AREA_W-1:0] rem_reg [3];
    logic [AREA_W:0]   rem_sh [3];
    logic              fits [3];

    logic [COLOR_W-1:0] avg;
    logic [COLOR_W-1:0] prev_reg;
    logic [COLOR_W-1:0] prev_next;

    token_item_t tok_reg;
    logic        tok_valid_reg;

    // register clamping
    always_comb
    begin
        if (img_w_reg == '0)
            w_c = IMG_W_W'(1);
        else if ({1'b0, img_w_reg} > MaxWidth)
            w_c = MaxWidth[IMG_W_W-1:0];
        else
            w_c = img_w_reg;

        if (img_h_reg == '0)
            h_c = IMG_H_W'(1);
        else if (img_h_reg > MAX_HEIGHT)
            h_c = MAX_HEIGHT;
        else
            h_c = img_h_reg;

        if (blk_w_reg == '0)
            bw_c = BLK_W'(1);
        else if ({2'b00, blk_w_reg} > MaxBlock)
            bw_c = MaxBlock[BLK_W-1:0];
        else
            bw_c = blk_w_reg;

        if (blk_h_reg == '0)
            bh_c = BLK_W'(1);
        else if ({2'b00, blk_h_reg} > MaxBlock)
            bh_c = MaxBlock[BLK_W-1:0];
        else
            bh_c = blk_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= IMG_W_W'(1);
            img_h_reg <= IMG_H_W'(1);
            blk_w_reg <= BLK_W'(1);
            blk_h_reg <= BLK_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data[IMG_H_W-1:0];
                CFG_BLOCK_WIDTH:  blk_w_reg <= cfg_data[BLK_W-1:0];
                CFG_BLOCK_HEIGHT: blk_h_reg <= cfg_data[BLK_W-1:0];
                default:          img_w_reg <= img_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(bw_c) * AREA_W'(bh_c);
    end

    // position tracking
    assign col_end  = IMG_W_W'(col_reg) == (w_c - IMG_W_W'(1));
    assign row_last = row_reg == ROW_W'(h_c - IMG_H_W'(1));
    assign cx_end   = cx_reg == (bw_c - BLK_W'(1));
    assign ry_end   = ry_reg == (bh_c - BLK_W'(1));
    assign in_col   = (13'(tstart_reg) + 13'(bw_c)) <= 13'(w_c);
    assign in_row   = (14'(rstart_reg) + 14'(bh_c)) <= 14'(h_c);
    assign in_tile  = in_col && in_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            tstart_reg <= '0;
            tile_reg   <= '0;
            cx_reg     <= '0;
            row_reg    <= '0;
            rstart_reg <= '0;
            ry_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            col_reg    <= '0;
            tstart_reg <= '0;
            tile_reg   <= '0;
            cx_reg     <= '0;
            row_reg    <= '0;
            rstart_reg <= '0;
            ry_reg     <= '0;
        end
        else if (cmd.accept)
        begin
            if (col_end)
            begin
                col_reg    <= '0;
                tstart_reg <= '0;
                tile_reg   <= '0;
                cx_reg     <= '0;
                if (row_last)
                begin
                    row_reg    <= '0;
                    rstart_reg <= '0;
                    ry_reg     <= '0;
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                    if (ry_end)
                    begin
                        ry_reg     <= '0;
                        rstart_reg <= rstart_reg + ROW_W'(bh_c);
                    end
                    else
                    begin
                        ry_reg <= ry_reg + BLK_W'(1);
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
                if (cx_end)
                begin
                    cx_reg     <= '0;
                    tile_reg   <= tile_reg + COL_W'(1);
                    tstart_reg <= tstart_reg + COL_W'(bw_c);
                end
                else
                begin
                    cx_reg <= cx_reg + BLK_W'(1);
                end
            end
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg     <= pix;
            first_reg  <= (cx_reg == '0) && (ry_reg == '0);
            last_reg   <= in_tile && cx_end && ry_end;
            rowend_reg <= col_end && in_row && ry_end;
            wrap_reg   <= col_end && row_last;
            tidx_reg   <= tile_reg;
        end
    end

    // tile accumulators
    assign px_c[0] = px_reg.red;
    assign px_c[1] = px_reg.green;
    assign px_c[2] = px_reg.blue;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = (first_reg ? '0 : rd_data[(2-c)*SUM_W +: SUM_W]) + SUM_W'(px_c[c]);
        end
    end

    assign wr_data = {sum[0], sum[1], sum[2]};

    bacre_ram #(
        .WIDTH (3 * SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_tile_ram (
        .clk     (clk),
        .wr_en   (cmd.acc),
        .wr_addr (tidx_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (tile_reg),
        .rd_data (rd_data)
    );

    // restoring divide by tile area, one quotient bit per cycle per channel
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rem_sh[c] = {rem_reg[c], quo_reg[c][SUM_W-1]};
            fits[c]   = rem_sh[c] >= {1'b0, area_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.acc)
            begin
                quo_reg[c] <= sum[c];
                rem_reg[c] <= '0;
            end
            else if (cmd.div_step)
            begin
                quo_reg[c] <= {quo_reg[c][SUM_W-2:0], fits[c]};
                rem_reg[c] <= fits[c] ? AREA_W'(rem_sh[c] - {1'b0, area_reg})
                                      : rem_sh[c][AREA_W-1:0];
            end
        end
    end

    assign avg = {quo_reg[0][CHAN_W-1:0], quo_reg[1][CHAN_W-1:0], quo_reg[2][CHAN_W-1:0]};

    // last color sent
    always_comb
    begin
        prev_next = last_reg ? avg : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else if (cfg_wr_en)
            prev_reg <= '0;
        else if (cmd.commit)
            prev_reg <= wrap_reg ? '0 : prev_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else if (cmd.push)
            tok_valid_reg <= 1'b1;
        else if (tok_ready)
            tok_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            tok_reg.token       <= cmd.tok_code;
            tok_reg.out_red     <= (cmd.tok_code == TOK_SET) ? avg[2*CHAN_W +: CHAN_W] : '0;
            tok_reg.out_green   <= (cmd.tok_code == TOK_SET) ? avg[CHAN_W +: CHAN_W] : '0;
            tok_reg.out_blue    <= (cmd.tok_code == TOK_SET) ? avg[0 +: CHAN_W] : '0;
            tok_reg.last_of_run <= cmd.last_run;
        end
    end

    assign tok       = tok_reg;
    assign tok_valid = tok_valid_reg;

    assign sts.in_tile    = in_tile;
    assign sts.last       = last_reg;
    assign sts.rowend     = rowend_reg;
    assign sts.need_color = last_reg && (avg != prev_reg);
    assign sts.need_reset = rowend_reg && (prev_next != '0);
    assign sts.avg_zero   = avg == '0;
    assign sts.out_free   = !tok_valid_reg || tok_ready;

endmodule

// ===== sv/bacre_ctrl.sv =====
`include "block_average_color_run_encoder_defines.svh"

module bacre_ctrl import bacre_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (state_reg == S_ACC)
            div_cnt_reg <= '0;
        else if (state_reg == S_DIV)
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_valid)
                    state_next = sts.in_tile ? S_ACC : S_COLOR;
            end
            S_ACC:
            begin
                state_next = sts.last ? S_DIV : S_COLOR;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                    state_next = S_COLOR;
            end
            S_COLOR:
            begin
                if (!sts.need_color || sts.out_free)
                    state_next = S_SPACE;
            end
            S_SPACE:
            begin
                if (!sts.last || sts.out_free)
                    state_next = S_RESET;
            end
            S_RESET:
            begin
                if (!sts.need_reset || sts.out_free)
                    state_next = S_NEWLINE;
            end
            S_NEWLINE:
            begin
                if (!sts.rowend || sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pix_ready    = 1'b0;
        cmd          = '0;
        cmd.tok_code = TOK_SPACE;
        unique case (state_reg)
            S_IDLE:
            begin
                pix_ready  = 1'b1;
                cmd.accept = pix_valid;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_COLOR:
            begin
                cmd.push     = sts.need_color && sts.out_free;
                cmd.tok_code = sts.avg_zero ? TOK_RESET : TOK_SET;
            end
            S_SPACE:
            begin
                cmd.push     = sts.last && sts.out_free;
                cmd.tok_code = TOK_SPACE;
                cmd.last_run = !sts.rowend;
            end
            S_RESET:
            begin
                cmd.push     = sts.need_reset && sts.out_free;
                cmd.tok_code = TOK_RESET;
            end
            S_NEWLINE:
            begin
                cmd.push     = sts.rowend && sts.out_free;
                cmd.tok_code = TOK_NEWLINE;
                cmd.last_run = 1'b1;
                cmd.commit   = !sts.rowend || sts.out_free;
            end
            default:
            begin
                pix_ready = 1'b0;
            end
        endcase
    end

    `BACRE_ASSERT(a_push_has_room, cmd.push, sts.out_free)
    `BACRE_ASSERT_NEXT(a_tile_pixel_accumulates, cmd.accept && sts.in_tile, state_reg == S_ACC)
    `BACRE_ASSERT(a_div_full_length, (state_reg == S_DIV) && (state_next != S_DIV), div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
    `BACRE_ASSERT(a_color_only_on_tile_end, cmd.push && (cmd.tok_code == TOK_SET), sts.last && sts.need_color)

endmodule

// ===== sv/block_average_color_run_encoder.sv =====
// channel   | dir | handshake     | payload
// ----------+-----+---------------+-------------------------------------------------
// pixels    | in  | valid / ready | red, green, blue
// tokens    | out | valid / ready | token, out_red, out_green, out_blue, last_of_run
// cfg       | in  | cfg_wr_en     | cfg_index, cfg_data
//
// One pixel at a time: a pixel outside every whole tile goes straight to the token
// states; one inside a tile is first accumulated, and the last pixel of a tile
// also runs the bit-serial divide by tile area before its tokens.
// A token state with a token to send holds while the output register is full and not being taken.
// The output register lets the next pixel enter while the last token waits.
// rst_n clears control state and the last color; the tile store needs no clearing.
module block_average_color_run_encoder import bacre_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bacre_pixel_if.sink           pixels,
    bacre_token_if.source         tokens
);

    pixel_t      pix;
    ctrl_cmd_t   cmd;
    dp_status_t  sts;
    token_item_t tok;
    logic        tok_valid;

    assign pix.red   = pixels.red;
    assign pix.green = pixels.green;
    assign pix.blue  = pixels.blue;

    bacre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pixels.valid),
        .pix_ready (pixels.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bacre_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .cmd       (cmd),
        .sts       (sts),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_ready (tokens.ready)
    );

    assign tokens.valid       = tok_valid;
    assign tokens.token       = tok.token;
    assign tokens.out_red     = tok.out_red;
    assign tokens.out_green   = tok.out_green;
    assign tokens.out_blue    = tok.out_blue;
    assign tokens.last_of_run = tok.last_of_run;

endmodule
